// ===== hw/rtl/ppim1_pkg.sv =====
`default_nettype none
package ppim1_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_STROBE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PORT_A  = 2'd0,
    REG_PORT_B  = 2'd1,
    REG_PORT_C  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_t;

  localparam logic [6:0] MODE_FIELD_MASK = 7'h70;
  localparam logic [6:0] MODE1_INPUT     = 7'h30;
  localparam logic [7:0] HANDSHAKE_KEEP  = 8'hC7;
  localparam logic [7:0] PC_IBF          = 8'h20;
  localparam logic [7:0] PC_INTE         = 8'h10;
  localparam logic [7:0] PC_INTR         = 8'h08;

  // Mode word bits that turn a port (or port C nibble) into an input
  localparam int unsigned MODE_A_IN    = 4;
  localparam int unsigned MODE_C_HI_IN = 3;
  localparam int unsigned MODE_B_IN    = 1;
  localparam int unsigned MODE_C_LO_IN = 0;

  // Control write: bit 7 selects mode set, else single-bit set/reset of port C
  localparam int unsigned CTRL_MODE_SET = 7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] reg_index;
    logic [7:0] data_value;
    logic [7:0] pin_a;
    logic [7:0] pin_b;
    logic [7:0] pin_c;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic [7:0] drive_c;
  } result_t;

  function automatic logic mode1_input(input logic [6:0] mode);
    return (mode & MODE_FIELD_MASK) == MODE1_INPUT;
  endfunction

  // Port C as seen on the pins: handshake bits replace latch bits in mode 1 input
  function automatic logic [7:0] port_c_effective(input logic [7:0] c_latch,
                                                  input logic [6:0] mode,
                                                  input logic       ibf);
    logic [7:0] v;
    v = c_latch;
    if (mode1_input(mode)) begin
      v = v & HANDSHAKE_KEEP;
      if (ibf) begin
        v = v | PC_IBF;
        if ((c_latch & PC_INTE) != 8'h00) begin
          v = v | PC_INTR;
        end
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ppim1_in_if.sv =====
`default_nettype none
interface ppim1_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] reg_index;
  logic [7:0] data_value;
  logic [7:0] pin_a;
  logic [7:0] pin_b;
  logic [7:0] pin_c;

  modport source (output valid, output cmd, output reg_index, output data_value,
                  output pin_a, output pin_b, output pin_c, input ready);
  modport sink (input valid, input cmd, input reg_index, input data_value,
                input pin_a, input pin_b, input pin_c, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppim1_out_if.sv =====
`default_nettype none
interface ppim1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] drive_a;
  logic [7:0] drive_b;
  logic [7:0] drive_c;

  modport source (output valid, output read_data, output drive_a, output drive_b,
                  output drive_c, input ready);
  modport sink (input valid, input read_data, input drive_a, input drive_b,
                input drive_c, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppim1_core.sv =====
`default_nettype none
module ppim1_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ppim1_pkg::item_t  item,
  output ppim1_pkg::result_t result
);

  logic [7:0] a_latch, a_latch_next;
  logic [7:0] b_latch, b_latch_next;
  logic [7:0] c_latch, c_latch_next;
  logic [6:0] mode, mode_next;
  logic       ibf, ibf_next;
  logic [7:0] strobed, strobed_next;

  logic [7:0] c_eff;
  logic [7:0] c_bit;
  logic [7:0] read_data;

  assign c_eff = ppim1_pkg::port_c_effective(c_latch, mode, ibf);
  assign c_bit = 8'h01 << item.data_value[3:1];

  always_comb begin
    a_latch_next = a_latch;
    b_latch_next = b_latch;
    c_latch_next = c_latch;
    mode_next    = mode;
    ibf_next     = ibf;
    strobed_next = strobed;
    read_data    = 8'h00;

    case (item.cmd)
      ppim1_pkg::CMD_READ: begin
        case (item.reg_index)
          ppim1_pkg::REG_PORT_A: begin
            ibf_next = 1'b0;
            if (ppim1_pkg::mode1_input(mode)) begin
              read_data = strobed;
            end else if (mode[ppim1_pkg::MODE_A_IN]) begin
              read_data = item.pin_a;
            end else begin
              read_data = a_latch;
            end
          end
          ppim1_pkg::REG_PORT_B: begin
            read_data = mode[ppim1_pkg::MODE_B_IN] ? item.pin_b : b_latch;
          end
          ppim1_pkg::REG_PORT_C: begin
            read_data[7:4] = mode[ppim1_pkg::MODE_C_HI_IN] ? item.pin_c[7:4] : c_eff[7:4];
            read_data[3:0] = mode[ppim1_pkg::MODE_C_LO_IN] ? item.pin_c[3:0] : c_eff[3:0];
          end
          default: begin
            read_data = {1'b0, mode};
          end
        endcase
      end
      ppim1_pkg::CMD_WRITE: begin
        case (item.reg_index)
          ppim1_pkg::REG_PORT_A: a_latch_next = item.data_value;
          ppim1_pkg::REG_PORT_B: b_latch_next = item.data_value;
          ppim1_pkg::REG_PORT_C: c_latch_next = item.data_value;
          default: begin
            if (item.data_value[ppim1_pkg::CTRL_MODE_SET]) begin
              mode_next = item.data_value[6:0];
            end else if (item.data_value[0]) begin
              c_latch_next = c_latch | c_bit;
            end else begin
              c_latch_next = c_latch & ~c_bit;
            end
          end
        endcase
      end
      ppim1_pkg::CMD_STROBE: begin
        ibf_next     = 1'b1;
        strobed_next = item.data_value;
      end
      default: begin
      end
    endcase

    result.read_data = read_data;
    result.drive_a   = a_latch_next;
    result.drive_b   = b_latch_next;
    result.drive_c   = ppim1_pkg::port_c_effective(c_latch_next, mode_next, ibf_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_latch <= 8'h00;
      b_latch <= 8'h00;
      c_latch <= 8'h00;
      mode    <= 7'h00;
      ibf     <= 1'b0;
      strobed <= 8'h00;
    end else if (accept) begin
      a_latch <= a_latch_next;
      b_latch <= b_latch_next;
      c_latch <= c_latch_next;
      mode    <= mode_next;
      ibf     <= ibf_next;
      strobed <= strobed_next;
    end
  end

`ifndef SYNTH
  a_strobe_sets_ibf: assert property (@(posedge clk) disable iff (rst)
    (accept && item.cmd == ppim1_pkg::CMD_STROBE) |=> (ibf && strobed == $past(item.data_value)))
    else $error("strobe did not set buffer-full");

  a_read_a_clears_ibf: assert property (@(posedge clk) disable iff (rst)
    (accept && item.cmd == ppim1_pkg::CMD_READ && item.reg_index == ppim1_pkg::REG_PORT_A)
    |=> !ibf)
    else $error("port A read left buffer-full set");

  a_mode_set: assert property (@(posedge clk) disable iff (rst)
    (accept && item.cmd == ppim1_pkg::CMD_WRITE && item.reg_index == ppim1_pkg::REG_CONTROL
     && item.data_value[ppim1_pkg::CTRL_MODE_SET])
    |=> (mode == $past(item.data_value[6:0]) && c_latch == $past(c_latch)))
    else $error("mode set wrong or disturbed port C latch");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/parallel_port_interface_mode1.sv =====
`default_nettype none
// Parallel port interface with ports A, B, C and a control register. Every item
// (bus read, bus write, or port A strobe) is handled as it is accepted: the register
// file updates at the accepting edge and the result lands in an output register,
// so one item per cycle is sustained while results are taken. A two-entry
// output stage (result register plus skid register) lets the input keep accepting
// while a result waits; ready drops only when both entries are full. Port A
// mode 1 input handshake drives port C bits 5 (buffer full) and 3 (interrupt).
module parallel_port_interface_mode1 (
  input logic         clk,
  input logic         rst,
  ppim1_in_if.sink    items,
  ppim1_out_if.source results
);

  ppim1_pkg::item_t   item;
  ppim1_pkg::result_t step_result;
  ppim1_pkg::result_t main_data;
  ppim1_pkg::result_t skid_data;
  logic               main_valid;
  logic               skid_valid;
  logic               accept;
  logic               take;

  assign item.cmd        = items.cmd;
  assign item.reg_index  = items.reg_index;
  assign item.data_value = items.data_value;
  assign item.pin_a      = items.pin_a;
  assign item.pin_b      = items.pin_b;
  assign item.pin_c      = items.pin_c;

  assign items.ready = !skid_valid;
  assign accept      = items.valid && !skid_valid;
  assign take        = main_valid && results.ready;

  ppim1_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain skid into the result register once it is taken
      if (take) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!main_valid || take) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        main_data <= skid_data;
      end
    end else if (accept) begin
      if (!main_valid || take) begin
        main_data <= step_result;
      end else begin
        skid_data <= step_result;
      end
    end
  end

  assign results.valid     = main_valid;
  assign results.read_data = main_data.read_data;
  assign results.drive_a   = main_data.drive_a;
  assign results.drive_b   = main_data.drive_b;
  assign results.drive_c   = main_data.drive_c;

`ifndef SYNTH
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without a result entry");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && results.ready) |=> (main_valid && !skid_valid))
    else $error("skid entry not moved forward after take");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (accept && !main_valid) |=> (main_valid && main_data == $past(step_result)))
    else $error("accepted item did not reach the result register");
`endif

endmodule
`default_nettype wire

// ===== bench/parallel_port_interface_mode1_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module parallel_port_interface_mode1_tb;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned ITEM_COUNT  = 625;
  localparam int unsigned QUIET_AFTER = 480;

  // Shadow of the port registers; predicts the port state after every item
  class port_scoreboard;
    logic [7:0]         a_latch;
    logic [7:0]         b_latch;
    logic [7:0]         c_latch;
    logic [7:0]         strobe_latch;
    logic [6:0]         mode;
    logic               ibf;
    ppim1_pkg::result_t expected_ports[$];
    int                 errors;

    function new();
      a_latch      = '0;
      b_latch      = '0;
      c_latch      = '0;
      strobe_latch = '0;
      mode         = '0;
      ibf          = 1'b0;
      errors       = 0;
    endfunction

    function logic in_mode1();
      return (mode & ppim1_pkg::MODE_FIELD_MASK) == ppim1_pkg::MODE1_INPUT;
    endfunction

    // Handshake bits override latch bits 5:3 in mode 1 input
    function logic [7:0] port_c_drive();
      logic [7:0] v;
      v = c_latch;
      if (in_mode1()) begin
        v = v & ppim1_pkg::HANDSHAKE_KEEP;
        if (ibf) begin
          v = v | ppim1_pkg::PC_IBF;
          if ((c_latch & ppim1_pkg::PC_INTE) != 8'h00) v = v | ppim1_pkg::PC_INTR;
        end
      end
      return v;
    endfunction

    function logic [7:0] read_reg(ppim1_pkg::item_t it);
      logic [7:0] c_now;
      c_now = port_c_drive();
      case (ppim1_pkg::reg_t'(it.reg_index))
        ppim1_pkg::REG_PORT_A: begin
          ibf = 1'b0;
          if (in_mode1()) return strobe_latch;
          return mode[ppim1_pkg::MODE_A_IN] ? it.pin_a : a_latch;
        end
        ppim1_pkg::REG_PORT_B: return mode[ppim1_pkg::MODE_B_IN] ? it.pin_b : b_latch;
        ppim1_pkg::REG_PORT_C:
          return {mode[ppim1_pkg::MODE_C_HI_IN] ? it.pin_c[7:4] : c_now[7:4],
                  mode[ppim1_pkg::MODE_C_LO_IN] ? it.pin_c[3:0] : c_now[3:0]};
        default: return {1'b0, mode};
      endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] v);
      case (ppim1_pkg::reg_t'(idx))
        ppim1_pkg::REG_PORT_A: a_latch = v;
        ppim1_pkg::REG_PORT_B: b_latch = v;
        ppim1_pkg::REG_PORT_C: c_latch = v;
        default: begin
          if (v[ppim1_pkg::CTRL_MODE_SET]) mode = v[6:0];
          else c_latch[v[3:1]] = v[0];
        end
      endcase
    endfunction

    function void note_item(ppim1_pkg::item_t it);
      ppim1_pkg::result_t r;
      r = '0;
      case (ppim1_pkg::cmd_t'(it.cmd))
        ppim1_pkg::CMD_READ:  r.read_data = read_reg(it);
        ppim1_pkg::CMD_WRITE: write_reg(it.reg_index, it.data_value);
        ppim1_pkg::CMD_STROBE: begin
          ibf          = 1'b1;
          strobe_latch = it.data_value;
        end
        default: ;
      endcase
      r.drive_a = a_latch;
      r.drive_b = b_latch;
      r.drive_c = port_c_drive();
      expected_ports.push_back(r);
    endfunction

    function void check_result(ppim1_pkg::result_t got);
      ppim1_pkg::result_t want;
      if (expected_ports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: rd=%02h a=%02h b=%02h c=%02h",
                   got.read_data, got.drive_a, got.drive_b, got.drive_c);
        return;
      end
      want = expected_ports.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp rd=%02h a=%02h b=%02h c=%02h got rd=%02h a=%02h b=%02h c=%02h",
                   want.read_data, want.drive_a, want.drive_b, want.drive_c,
                   got.read_data, got.drive_a, got.drive_b, got.drive_c);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned cycles;
  int unsigned sent_items;
  int unsigned stall_left;
  bit idle_on;
  port_scoreboard sb;

  ppim1_in_if  items_if ();
  ppim1_out_if results_if ();

  parallel_port_interface_mode1 uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("parallel_port_interface_mode1_tb failed");
      $finish;
    end
  end

  // Output stalls come in bursts, only while idle_on is set
  always @(negedge clk) begin
    if (stall_left != 0) begin
      results_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      results_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result({results_if.read_data, results_if.drive_a,
                       results_if.drive_b, results_if.drive_c});
  end

  task automatic drive_item(input ppim1_pkg::item_t it);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    items_if.valid      <= 1'b1;
    items_if.cmd        <= it.cmd;
    items_if.reg_index  <= it.reg_index;
    items_if.data_value <= it.data_value;
    items_if.pin_a      <= it.pin_a;
    items_if.pin_b      <= it.pin_b;
    items_if.pin_c      <= it.pin_c;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sb.note_item(it);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_pins(input ppim1_pkg::cmd_t c, input ppim1_pkg::reg_t r,
                           input logic [7:0] d, input logic [7:0] pa,
                           input logic [7:0] pb, input logic [7:0] pc);
    drive_item({c, r, d, pa, pb, pc});
  endtask

  task automatic send_op(input ppim1_pkg::cmd_t c, input ppim1_pkg::reg_t r,
                         input logic [7:0] d);
    send_pins(c, r, d, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // Typical mode 1 input exchange: set mode, arm interrupt, strobe, poll, read
  task automatic run_handshake();
    if ($urandom_range(0, 2) == 0)
      send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL,
              {1'b1, 3'b011, 4'($urandom_range(0, 15))});
    if ($urandom_range(0, 1) == 1)
      send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL,
              {4'b0000, 3'd4, 1'($urandom_range(0, 1))});
    repeat ($urandom_range(1, 2))
      send_op(ppim1_pkg::CMD_STROBE, ppim1_pkg::reg_t'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)));
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_C, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0)
      send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_A, 8'($urandom_range(0, 255)));
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_C, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [7:0] d;
    pick = $urandom_range(0, 99);
    d    = 8'($urandom_range(0, 255));
    if (pick < 6)
      send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, {1'b1, d[6:0]});
    else if (pick < 14)
      send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, {1'b0, d[6:0]});
    else if (pick < 30)
      send_op(ppim1_pkg::CMD_STROBE, ppim1_pkg::reg_t'($urandom_range(0, 3)), d);
    else if (pick < 60)
      send_op(ppim1_pkg::CMD_READ, ppim1_pkg::reg_t'($urandom_range(0, 3)), d);
    else if (pick < 94)
      send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::reg_t'($urandom_range(0, 2)), d);
    else
      send_op(ppim1_pkg::CMD_NONE, ppim1_pkg::reg_t'($urandom_range(0, 3)), d);
  endtask

  initial begin
    sb                    = new();
    cycles                = 0;
    sent_items            = 0;
    stall_left            = 0;
    idle_on               = 1'b1;
    rst                   = 1'b1;
    results_if.ready      = 1'b0;
    items_if.valid        = 1'b0;
    items_if.cmd          = ppim1_pkg::CMD_NONE;
    items_if.reg_index    = ppim1_pkg::REG_PORT_A;
    items_if.data_value   = '0;
    items_if.pin_a        = '0;
    items_if.pin_b        = '0;
    items_if.pin_c        = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset state of every register
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_A, 8'h00);
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_B, 8'h00);
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_C, 8'h00);
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_CONTROL, 8'h00);
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_PORT_A, 8'hFF);
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_PORT_B, 8'hFF);
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_PORT_C, 8'hFF);
    send_pins(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_B, 8'h00, 8'h00, 8'h55, 8'h00);
    // All ports as inputs; mode set must keep the latches
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, 8'hFF);
    send_pins(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_A, 8'hFF, 8'hA5, 8'h00, 8'h00);
    send_pins(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_B, 8'h00, 8'h00, 8'h5A, 8'h00);
    send_pins(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_C, 8'h00, 8'h00, 8'h00, 8'h3C);
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_CONTROL, 8'hFF);
    // Mode 1 input on port A
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, 8'hB0);
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, 8'h08);
    send_op(ppim1_pkg::CMD_STROBE, ppim1_pkg::REG_CONTROL, 8'h00);
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, 8'h09);
    send_op(ppim1_pkg::CMD_STROBE, ppim1_pkg::REG_PORT_A, 8'hFF);
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_C, 8'h00);
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_A, 8'h00);
    send_op(ppim1_pkg::CMD_NONE, ppim1_pkg::REG_PORT_C, 8'hFF);
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, 8'h0E);
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, 8'h01);
    // Strobe outside mode 1 still fills the buffer
    send_op(ppim1_pkg::CMD_WRITE, ppim1_pkg::REG_CONTROL, 8'h80);
    send_op(ppim1_pkg::CMD_STROBE, ppim1_pkg::REG_PORT_B, 8'h5A);
    send_op(ppim1_pkg::CMD_READ, ppim1_pkg::REG_PORT_A, 8'h00);

    while (sent_items < ITEM_COUNT) begin
      idle_on = (sent_items < QUIET_AFTER);
      if ($urandom_range(0, 3) == 0) run_handshake();
      else send_random();
    end
    items_if.valid <= 1'b0;

    while (sb.expected_ports.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.expected_ports.size() == 0) begin
      $display("parallel_port_interface_mode1_tb passed");
    end else begin
      $display("parallel_port_interface_mode1_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/ppim1_pkg.sv
hw/rtl/ppim1_in_if.sv
hw/rtl/ppim1_out_if.sv
hw/rtl/ppim1_core.sv
hw/rtl/parallel_port_interface_mode1.sv
bench/parallel_port_interface_mode1_tb.sv
